[hdl/chb_pkg.sv]
`timescale 1ns / 1ps

package chb_pkg;

   localparam int NUM_SYMBOLS_DEF  = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   localparam int WORD_W      = 32;
   localparam int BYTES_W     = 28;
   localparam int TOTAL_W     = 31;
   localparam int SYM_FIELD_W = 8;
   localparam int LEN_FIELD_W = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_BUILD  = 2'd1,
      OP_ENCODE = 2'd2,
      OP_END    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BLD_IDLE,
      BLD_WALK,
      BLD_DRAIN
   } build_state_type;

   // classified item as it travels from front to back
   typedef struct packed {
      op_type                   op;
      logic [SYM_FIELD_W-1:0]   sym;
      logic                     sym_ok;
      logic [LEN_FIELD_W-1:0]   len;
   } item_type;

endpackage

[hdl/chb_front.sv]
`timescale 1ns / 1ps

module chb_front #(
   parameter int NUM_SYMBOLS  = chb_pkg::NUM_SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = chb_pkg::MAX_CODE_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic [7:0]       req_symbol,
   input  logic [7:0]       req_code_length,
   output logic             item_valid,
   input  logic             item_ready,
   output chb_pkg::item_type item
);

   logic              valid_ff, valid_in;
   chb_pkg::item_type item_ff, item_in;
   logic              len_ok;

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      len_ok         = (req_code_length >= 8'd1) &&
                       (req_code_length <= 8'(MAX_CODE_LEN));
      item_in.op     = chb_pkg::op_type'(req_func);
      item_in.sym    = req_symbol;
      item_in.sym_ok = ({1'b0, req_symbol} < 9'(NUM_SYMBOLS));
      // out-of-range lengths store the symbol as unused
      item_in.len    = len_ok ? req_code_length[chb_pkg::LEN_FIELD_W-1:0] : '0;
      valid_in       = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

[hdl/chb_queue.sv]
`timescale 1ns / 1ps

module chb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  chb_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output chb_pkg::item_type out_item
);

   localparam int DEPTH = chb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   chb_pkg::item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[hdl/chb_back.sv]
`timescale 1ns / 1ps

module chb_back #(
   parameter int NUM_SYMBOLS  = chb_pkg::NUM_SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = chb_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  chb_pkg::item_type             item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [chb_pkg::WORD_W-1:0]    rsp_word,
   output logic                          rsp_word_valid,
   output logic                          rsp_slice_last,
   output logic [chb_pkg::BYTES_W-1:0]   rsp_slice_bytes,
   output logic                          rsp_symbol_error
);

   localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int WW    = chb_pkg::WORD_W;
   localparam int TW    = chb_pkg::TOTAL_W;
   localparam int BW    = chb_pkg::BYTES_W;

   // symbol tables
   logic [LEN_W-1:0] len_mem  [NUM_SYMBOLS];
   logic [WW-1:0]    code_mem [NUM_SYMBOLS];
   logic [LEN_W-1:0] len_rd_ff;
   logic [WW-1:0]    code_rd_ff;
   logic [SYM_W-1:0] rd_addr;
   logic             rd_en;

   // build sequencer
   chb_pkg::build_state_type state_ff, state_in;
   logic [LEN_W-1:0] walk_len_ff, walk_len_in;
   logic [SYM_W-1:0] walk_sym_ff, walk_sym_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [LEN_W-1:0] cmp_len_ff;
   logic [SYM_W-1:0] cmp_sym_ff;
   logic [WW-1:0]    build_code_ff, build_code_in;
   logic             cmp_hit;
   logic             cmp_first;
   logic [5:0]       cmp_len6;

   // pack stage
   logic             s1_valid_ff, s1_valid_in;
   chb_pkg::op_type  s1_op_ff;
   logic             s1_sym_ok_ff;
   logic             s1_fire, pop;
   logic [WW-1:0]    acc_ff, acc_in;
   logic [4:0]       fill_ff, fill_in;
   logic [TW-1:0]    total_ff, total_in;

   logic [5:0]       len6, n6, add_amt;
   logic             sym_err;
   logic [WW-1:0]    code_al;
   logic [2*WW-1:0]  merged;
   logic [WW:0]      sum;
   logic [TW-1:0]    tot_sat, tot_rep;
   logic [WW-1:0]    words;
   logic [BW:0]      bytes_raw;

   logic             res_valid, res_word_valid, res_last, res_err;
   logic [WW-1:0]    res_word;
   logic [BW-1:0]    res_bytes;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]    rsp_word_ff;
   logic             rsp_word_valid_ff, rsp_slice_last_ff, rsp_symbol_error_ff;
   logic [BW-1:0]    rsp_slice_bytes_ff;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign item_ready = (state_ff == chb_pkg::BLD_IDLE) && (!s1_valid_ff || s1_fire);
   assign pop        = item_valid && item_ready;

   // ---------------- table access ----------------
   always_comb begin
      rd_addr = (state_ff == chb_pkg::BLD_WALK) ? walk_sym_ff : item.sym[SYM_W-1:0];
      rd_en   = (state_ff == chb_pkg::BLD_WALK) || pop;
   end

   always_ff @(posedge clock) begin
      if (pop && (item.op == chb_pkg::OP_LOAD) && item.sym_ok) begin
         len_mem[item.sym[SYM_W-1:0]] <= item.len[LEN_W-1:0];
      end
      if (rd_en) begin
         len_rd_ff <= len_mem[rd_addr];
      end
   end

   // first pass fills max-length codes, clears the rest; later passes fill used ones
   always_ff @(posedge clock) begin
      if (cmp_hit) begin
         code_mem[cmp_sym_ff] <= build_code_ff >> (6'd32 - cmp_len6);
      end else if (cmp_first) begin
         code_mem[cmp_sym_ff] <= '0;
      end
      if (pop) begin
         code_rd_ff <= code_mem[item.sym[SYM_W-1:0]];
      end
   end

   // ---------------- build walk ----------------
   // lengths from longest down, symbols from highest down; codes stored right-aligned
   always_comb begin
      cmp_len6      = 6'(cmp_len_ff);
      cmp_hit       = cmp_valid_ff && (len_rd_ff == cmp_len_ff);
      cmp_first     = cmp_valid_ff && (cmp_len_ff == LEN_W'(MAX_CODE_LEN));
      state_in      = state_ff;
      walk_len_in   = walk_len_ff;
      walk_sym_in   = walk_sym_ff;
      cmp_valid_in  = 1'b0;
      build_code_in = build_code_ff;
      if (cmp_hit) begin
         build_code_in = build_code_ff + (32'd1 << (6'd32 - cmp_len6));
      end
      unique case (state_ff)
         chb_pkg::BLD_IDLE: begin
            if (pop && (item.op == chb_pkg::OP_BUILD)) begin
               state_in      = chb_pkg::BLD_WALK;
               walk_len_in   = LEN_W'(MAX_CODE_LEN);
               walk_sym_in   = SYM_W'(NUM_SYMBOLS - 1);
               build_code_in = 32'd1;
            end
         end
         chb_pkg::BLD_WALK: begin
            cmp_valid_in = 1'b1;
            if (walk_sym_ff == '0) begin
               walk_sym_in = SYM_W'(NUM_SYMBOLS - 1);
               if (walk_len_ff == LEN_W'(1)) begin
                  state_in = chb_pkg::BLD_DRAIN;
               end else begin
                  walk_len_in = walk_len_ff - 1'b1;
               end
            end else begin
               walk_sym_in = walk_sym_ff - 1'b1;
            end
         end
         chb_pkg::BLD_DRAIN: begin
            state_in = chb_pkg::BLD_IDLE;
         end
         default: begin
            state_in = chb_pkg::BLD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= chb_pkg::BLD_IDLE;
         cmp_valid_ff  <= 1'b0;
         build_code_ff <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_valid_ff  <= cmp_valid_in;
         build_code_ff <= build_code_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_len_ff <= walk_len_in;
      walk_sym_ff <= walk_sym_in;
      cmp_len_ff  <= walk_len_ff;
      cmp_sym_ff  <= walk_sym_ff;
   end

   // ---------------- pack stage ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = (item.op == chb_pkg::OP_ENCODE) || (item.op == chb_pkg::OP_END);
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      len6    = 6'(len_rd_ff);
      sym_err = !s1_sym_ok_ff || (len6 == 6'd0) || (len6 > 6'(MAX_CODE_LEN));
      n6      = {1'b0, fill_ff} + len6;
      // low len bits of the code moved to the top
      code_al = code_rd_ff << (6'd32 - len6);
      // pending bits sit at the top of the accumulator, zeros below
      merged  = {acc_ff, {WW{1'b0}}} | ({code_al, {WW{1'b0}}} >> fill_ff);
      add_amt = (s1_op_ff == chb_pkg::OP_END) ? (6'd32 - {1'b0, fill_ff}) : len6;
      sum     = {2'b00, total_ff} + (WW + 1)'(add_amt);
      tot_sat = (sum > (WW + 1)'(chb_pkg::TOTAL_MAX)) ? chb_pkg::TOTAL_MAX : sum[TW-1:0];

      acc_in         = acc_ff;
      fill_in        = fill_ff;
      total_in       = total_ff;
      tot_rep        = total_ff;
      res_valid      = 1'b0;
      res_word       = '0;
      res_word_valid = 1'b0;
      res_last       = 1'b0;
      res_err        = 1'b0;

      if (s1_op_ff == chb_pkg::OP_END) begin
         res_valid = 1'b1;
         res_last  = 1'b1;
         if (fill_ff != 5'd0) begin
            res_word       = acc_ff;
            res_word_valid = 1'b1;
            tot_rep        = tot_sat;
         end
         acc_in   = '0;
         fill_in  = '0;
         total_in = '0;
      end else if (sym_err) begin
         res_valid = 1'b1;
         res_err   = 1'b1;
      end else begin
         total_in = tot_sat;
         tot_rep  = tot_sat;
         fill_in  = n6[4:0];
         if (n6[5]) begin
            res_valid      = 1'b1;
            res_word_valid = 1'b1;
            res_word       = merged[2*WW-1:WW];
            acc_in         = merged[WW-1:0];
         end else begin
            acc_in = merged[2*WW-1:WW];
         end
      end

      words     = ({1'b0, tot_rep} + 32'd31) >> 5;
      bytes_raw = {words[BW-2:0], 2'b00};
      res_bytes = bytes_raw[BW] ? chb_pkg::BYTES_MAX : bytes_raw[BW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
         fill_ff     <= '0;
         total_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_fire) begin
            acc_ff   <= acc_in;
            fill_ff  <= fill_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff     <= item.op;
         s1_sym_ok_ff <= item.sym_ok;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && res_valid) begin
         rsp_word_ff         <= res_word;
         rsp_word_valid_ff   <= res_word_valid;
         rsp_slice_last_ff   <= res_last;
         rsp_slice_bytes_ff  <= res_bytes;
         rsp_symbol_error_ff <= res_err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word         = rsp_word_ff;
   assign rsp_word_valid   = rsp_word_valid_ff;
   assign rsp_slice_last   = rsp_slice_last_ff;
   assign rsp_slice_bytes  = rsp_slice_bytes_ff;
   assign rsp_symbol_error = rsp_symbol_error_ff;

endmodule

[hdl/canonical_huffman_bit_packer_unit.sv]
`timescale 1ns / 1ps

// Canonical Huffman bit packer.
// Request channel (req_*): one beat per command. req_func selects load length,
// build codes, encode symbol or end slice; req_symbol and req_code_length go with it.
// Response channel (rsp_*): one beat for each full 32-bit word, each unused symbol
// encoded (rsp_symbol_error) and each slice end (rsp_slice_last, with the last
// padded word when bits were pending). Loads, builds and partial encodes give no beat.
// Response valid is registered: input register, queue, table read, then the response register.
// Load, encode and end commands sustain one per cycle while no build walks and no beat is stalled.
// A build walks every length from MAX_CODE_LEN down to 1 and, for each, every symbol
// through the single length-table read port, then passes a drain state; meanwhile later
// commands wait in the queue.
// Reset clears the bit accumulator, fill count, slice bit count and all handshake
// state; the length and code tables hold nothing defined until loaded and built.
// While a response beat waits on rsp_ready the response register holds it, the pack stage stops,
// and the queue and input register keep taking requests until they are full.
module canonical_huffman_bit_packer_unit #(
   parameter int NUM_SYMBOLS  = chb_pkg::NUM_SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = chb_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [7:0]                    req_symbol,
   input  logic [7:0]                    req_code_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [chb_pkg::WORD_W-1:0]    rsp_word,
   output logic                          rsp_word_valid,
   output logic                          rsp_slice_last,
   output logic [chb_pkg::BYTES_W-1:0]   rsp_slice_bytes,
   output logic                          rsp_symbol_error
);

   logic              f_valid, f_ready;
   chb_pkg::item_type f_item;
   logic              q_valid, q_ready;
   chb_pkg::item_type q_item;

   chb_front #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .item_valid      (f_valid),
      .item_ready      (f_ready),
      .item            (f_item)
   );

   chb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   chb_back #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (q_valid),
      .item_ready       (q_ready),
      .item             (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .rsp_word_valid   (rsp_word_valid),
      .rsp_slice_last   (rsp_slice_last),
      .rsp_slice_bytes  (rsp_slice_bytes),
      .rsp_symbol_error (rsp_symbol_error)
   );

endmodule

[hdl/chb_checker.sv]
`timescale 1ns / 1ps

module chb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_func,
   input logic [7:0]                    req_symbol,
   input logic [7:0]                    req_code_length,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [chb_pkg::WORD_W-1:0]    rsp_word,
   input logic                          rsp_word_valid,
   input logic                          rsp_slice_last,
   input logic [chb_pkg::BYTES_W-1:0]   rsp_slice_bytes,
   input logic                          rsp_symbol_error
);

   // a waiting request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_func) &&
         $stable(req_symbol) && $stable(req_code_length))
      else $error("request beat changed while waiting");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) &&
         $stable(rsp_word_valid) && $stable(rsp_slice_last) &&
         $stable(rsp_slice_bytes) && $stable(rsp_symbol_error))
      else $error("response beat changed while stalled");

   // an error beat carries no word and never ends a slice
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol_error |-> !rsp_word_valid && !rsp_slice_last)
      else $error("error beat with word or slice end");

   // every beat is a word, an error or a slice end, and an empty word reads zero
   a_beat_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_valid || rsp_symbol_error || rsp_slice_last) &&
         (rsp_word_valid || (rsp_word == '0)))
      else $error("response beat of no kind or non-zero empty word");

   // no response survives reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind canonical_huffman_bit_packer_unit chb_checker u_chb_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
   import chb_pkg::*;

   localparam int          CYCLE_LIMIT = 10_000_000;
   localparam int          MAX_LEN     = MAX_CODE_LEN_DEF;
   localparam bit [7:0]    UNUSED_LEN  = 8'hFF;

   typedef struct {
      logic [WORD_W-1:0]  word;
      logic               word_valid;
      logic               slice_last;
      logic [BYTES_W-1:0] slice_bytes;
      logic               symbol_error;
   } pack_beat_type;

   // mirrors the packer state and keeps the beats still owed by the block
   class bit_packer_tracker;
      bit [5:0]         len_tab [256];
      bit [31:0]        code_tab [256];
      bit [31:0]        acc;
      bit [5:0]         fill;
      bit [TOTAL_W-1:0] bit_total;
      bit [32:0]        walk_code;
      pack_beat_type    pending_beats [$];
      int               mismatches, n_checked, n_words, n_errors, n_ends, n_builds, n_encodes;

      function void add_bits(int n);
         if (longint'(bit_total) + n > longint'(TOTAL_MAX))
            bit_total = TOTAL_MAX;
         else
            bit_total = TOTAL_W'(longint'(bit_total) + n);
      endfunction

      function bit [BYTES_W-1:0] padded_bytes();
         longint unsigned b;
         b = ((longint'(bit_total) + 31) >> 5) * 4;
         if (b > longint'(BYTES_MAX))
            return BYTES_MAX;
         return b[BYTES_W-1:0];
      endfunction

      function void owe(bit [31:0] w, bit wv, bit last, bit err);
         pack_beat_type b;
         b.word         = w;
         b.word_valid   = wv;
         b.slice_last   = last;
         b.slice_bytes  = padded_bytes();
         b.symbol_error = err;
         pending_beats.push_back(b);
      endfunction

      // longest lengths and highest symbols take the smallest codes
      function void assign_codes();
         longint unsigned c;
         walk_code = 33'd1;
         foreach (code_tab[s])
            code_tab[s] = 32'd0;
         for (int len = MAX_LEN; len >= 1; len--) begin
            for (int s = 255; s >= 0; s--) begin
               if (len_tab[s] == len) begin
                  c = (longint'(walk_code) >> (32 - len)) & ((64'd1 << len) - 1);
                  code_tab[s] = c[31:0];
                  walk_code = walk_code + 33'(64'h8000_0000 >> (len - 1));
               end
            end
         end
      endfunction

      function void append_code(bit [7:0] sym);
         longint unsigned wide, w;
         int len, n;
         len = len_tab[sym];
         if (len == 0 || len > MAX_LEN) begin
            owe(32'd0, 1'b0, 1'b0, 1'b1);
            return;
         end
         wide = (longint'(acc) << len) | (longint'(code_tab[sym]) & ((64'd1 << len) - 1));
         n = fill + len;
         add_bits(len);
         if (n >= 32) begin
            w = wide >> (n - 32);
            fill = 6'(n - 32);
            acc = 32'(wide & ((64'd1 << fill) - 1));
            owe(w[31:0], 1'b1, 1'b0, 1'b0);
         end else begin
            acc = wide[31:0];
            fill = 6'(n);
         end
      endfunction

      function void close_slice();
         bit [31:0] w;
         if (fill > 0) begin
            w = acc << (32 - int'(fill));
            add_bits(32 - int'(fill));
            owe(w, 1'b1, 1'b1, 1'b0);
         end else begin
            owe(32'd0, 1'b0, 1'b1, 1'b0);
         end
         acc = 32'd0;
         fill = 6'd0;
         bit_total = '0;
      endfunction

      function void note_request(op_type op, bit [7:0] sym, bit [7:0] cl);
         case (op)
            OP_LOAD: begin
               len_tab[sym] = (cl >= 1 && cl <= MAX_LEN) ? cl[5:0] : 6'd0;
            end
            OP_BUILD: begin
               n_builds++;
               assign_codes();
            end
            OP_ENCODE: begin
               n_encodes++;
               append_code(sym);
            end
            default: begin
               close_slice();
            end
         endcase
      endfunction

      function void check_response(pack_beat_type got);
         pack_beat_type exp;
         n_checked++;
         if (got.word_valid === 1'b1)
            n_words++;
         if (got.symbol_error === 1'b1)
            n_errors++;
         if (got.slice_last === 1'b1)
            n_ends++;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected beat: word=%h wv=%b last=%b bytes=%0d err=%b",
                        $time, got.word, got.word_valid, got.slice_last,
                        got.slice_bytes, got.symbol_error);
            return;
         end
         exp = pending_beats.pop_front();
         if (got.word !== exp.word || got.word_valid !== exp.word_valid ||
             got.slice_last !== exp.slice_last || got.slice_bytes !== exp.slice_bytes ||
             got.symbol_error !== exp.symbol_error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] beat mismatch: exp word=%h wv=%b last=%b bytes=%0d err=%b",
                        $time, exp.word, exp.word_valid, exp.slice_last,
                        exp.slice_bytes, exp.symbol_error,
                        "\n   got word=%h wv=%b last=%b bytes=%0d err=%b",
                        got.word, got.word_valid, got.slice_last,
                        got.slice_bytes, got.symbol_error);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [1:0]          req_func        = OP_LOAD;
   logic [7:0]          req_symbol      = 8'd0;
   logic [7:0]          req_code_length = 8'd0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [WORD_W-1:0]   rsp_word;
   logic                rsp_word_valid;
   logic                rsp_slice_last;
   logic [BYTES_W-1:0]  rsp_slice_bytes;
   logic                rsp_symbol_error;

   bit_packer_tracker   sb = new;
   bit                  calm = 1'b0;
   int                  stall_left = 0;
   int                  cycles = 0;
   int                  n_items = 0;
   int                  stim_len [256];
   int                  live [$];

   canonical_huffman_bit_packer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_symbol       (req_symbol),
      .req_code_length  (req_code_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .rsp_word_valid   (rsp_word_valid),
      .rsp_slice_last   (rsp_slice_last),
      .rsp_slice_bytes  (rsp_slice_bytes),
      .rsp_symbol_error (rsp_symbol_error)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // mostly short idles, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   always @(posedge clock) begin
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
         stall_left = pick_gap();
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pack_beat_type got;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycles, sb.pending_beats.size());
         $display("FAILURE");
         $finish;
      end else if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.word         = rsp_word;
         got.word_valid   = rsp_word_valid;
         got.slice_last   = rsp_slice_last;
         got.slice_bytes  = rsp_slice_bytes;
         got.symbol_error = rsp_symbol_error;
         sb.check_response(got);
      end
   end

   task automatic send_req(op_type op, bit [7:0] sym, bit [7:0] cl);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= op;
      req_symbol      <= sym;
      req_code_length <= cl;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(op, sym, cl);
      n_items++;
   endtask

   task automatic load_len(bit [7:0] sym, bit [7:0] cl);
      stim_len[sym] = (cl >= 1 && cl <= MAX_LEN) ? cl : 0;
      send_req(OP_LOAD, sym, cl);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_beats.size() != 0);
   endtask

   function automatic void refresh_live();
      live.delete();
      for (int s = 0; s < 256; s++)
         if (stim_len[s] != 0)
            live.push_back(s);
   endfunction

   function automatic bit [7:0] pick_live();
      if (live.size() == 0)
         return 8'($urandom_range(0, 255));
      return 8'(live[$urandom_range(0, live.size() - 1)]);
   endfunction

   function automatic bit [7:0] rand_len();
      if ($urandom_range(0, 9) < 7)
         return 8'($urandom_range(1, MAX_LEN));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic bit [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // kraft-complete set of k lengths by splitting leaves, then all 256 symbols loaded
   task automatic load_complete_table(int k);
      int leaves [$];
      int perm [256];
      int idx, tmp, tries;
      bit [7:0] cl;
      leaves = '{1, 1};
      tries = 0;
      while (leaves.size() < k && tries < 20000) begin
         tries++;
         idx = $urandom_range(0, 1) ? leaves.size() - 1 : $urandom_range(0, leaves.size() - 1);
         if (leaves[idx] < MAX_LEN) begin
            leaves[idx]++;
            leaves.push_back(leaves[idx]);
         end
      end
      for (int i = 0; i < 256; i++)
         perm[i] = i;
      for (int i = 255; i > 0; i--) begin
         idx = $urandom_range(0, i);
         tmp = perm[i];
         perm[i] = perm[idx];
         perm[idx] = tmp;
      end
      for (int i = 0; i < 256; i++) begin
         if (i < leaves.size())
            cl = 8'(leaves[i]);
         else begin
            case ($urandom_range(0, 2))
               0:       cl = 8'd0;
               1:       cl = UNUSED_LEN;
               default: cl = 8'($urandom_range(MAX_LEN + 1, 254));
            endcase
         end
         load_len(8'(perm[i]), cl);
      end
   endtask

   task automatic run_phase();
      int n, r;
      bit [7:0] sym;
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0)
         load_complete_table($urandom_range(0, 1) ? $urandom_range(2, 24) : $urandom_range(2, 256));
      else
         repeat ($urandom_range(1, 12)) load_len(rand_byte(), rand_len());
      send_req(OP_BUILD, rand_byte(), rand_byte());
      refresh_live();
      n = $urandom_range(40, 160);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 80)
            send_req(OP_ENCODE, pick_live(), rand_byte());
         else if (r < 86)
            send_req(OP_ENCODE, rand_byte(), rand_byte());
         else if (r < 93)
            send_req(OP_END, rand_byte(), rand_byte());
         else if (r < 99) begin
            // length changed without a rebuild: the old code stays in use
            sym = rand_byte();
            load_len(sym, rand_len());
            refresh_live();
         end else begin
            send_req(OP_BUILD, rand_byte(), rand_byte());
         end
      end
      if ($urandom_range(0, 1))
         send_req(OP_END, rand_byte(), rand_byte());
      if ($urandom_range(0, 3) == 0)
         pause_until_drained();
   endtask

   initial begin
      bit [7:0] cl;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // every length entry is written before the first build reads them all
      calm = 1'b1;
      for (int s = 0; s < 256; s++) begin
         if (s == 0)
            cl = 8'd1;
         else if (s == 1)
            cl = 8'd2;
         else if (s == 2)
            cl = 8'd3;
         else if (s == 3)
            cl = 8'd0;
         else if (s == 4)
            cl = UNUSED_LEN;
         else if (s == 5)
            cl = 8'(MAX_LEN + 1);
         else if (s == 6)
            cl = 8'hC0;
         else if (s >= 254)
            cl = 8'(MAX_LEN);
         else
            cl = 8'(4 + s % 29);   // overfull on purpose, codes wrap
         load_len(8'(s), cl);
      end
      calm = 1'b0;
      send_req(OP_BUILD, 8'h00, 8'h00);

      send_req(OP_ENCODE, 8'hFF, 8'h00);   // full-length code straight into a word
      send_req(OP_ENCODE, 8'hFE, 8'hFF);
      send_req(OP_ENCODE, 8'h00, 8'h00);   // single bit, then padded out
      send_req(OP_END,    8'h00, 8'h00);
      send_req(OP_END,    8'hFF, 8'hFF);   // nothing pending
      send_req(OP_ENCODE, 8'h03, 8'h00);
      send_req(OP_ENCODE, 8'h04, 8'h00);
      send_req(OP_ENCODE, 8'h05, 8'h00);
      send_req(OP_ENCODE, 8'h06, 8'h00);
      send_req(OP_ENCODE, 8'h01, 8'h00);
      send_req(OP_ENCODE, 8'h02, 8'h00);
      send_req(OP_ENCODE, 8'h80, 8'h00);
      send_req(OP_ENCODE, 8'h7F, 8'h00);
      send_req(OP_ENCODE, 8'hFF, 8'h00);
      load_len(8'h00, UNUSED_LEN);
      send_req(OP_ENCODE, 8'h00, 8'h00);
      load_len(8'h00, 8'd1);
      send_req(OP_ENCODE, 8'h00, 8'h00);
      send_req(OP_ENCODE, 8'hFE, 8'h00);
      send_req(OP_END,    8'h00, 8'h00);
      pause_until_drained();

      while (n_items < 1950)
         run_phase();
      send_req(OP_END, rand_byte(), rand_byte());
      pause_until_drained();
      // a trailing build may still be walking the tables
      repeat (8300) @(posedge clock);

      $display("covered %0d requests: %0d code builds, %0d symbol encodes",
               n_items, sb.n_builds, sb.n_encodes);
      $display("%0d beats checked: %0d words, %0d slice ends, %0d unused-symbol errors, %0d bad",
               sb.n_checked, sb.n_words, sb.n_ends, sb.n_errors, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_beats.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[canonical_huffman_bit_packer_unit.f]
hdl/chb_pkg.sv
hdl/chb_front.sv
hdl/chb_queue.sv
hdl/chb_back.sv
hdl/canonical_huffman_bit_packer_unit.sv
hdl/chb_checker.sv
test/tb.sv
